// ----- design/pulse_tone_generator_defines.svh -----
// ----------------------------------------------------------------------------
// Pulse tone generator assertion macros
// Shared concurrent assertion forms for the pulse tone generator checkers.
// ----------------------------------------------------------------------------
`ifndef PULSE_TONE_GENERATOR_DEFINES_SVH
`define PULSE_TONE_GENERATOR_DEFINES_SVH

// Property checked on every rising edge outside of reset.
`define PTG_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Property checked on every rising edge, reset included.
`define PTG_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

// ----- design/ptg_pkg.sv -----
// ----------------------------------------------------------------------------
// Pulse tone generator package
// Types, constants and the amplitude table shared by the tone generator.
// ----------------------------------------------------------------------------
`default_nettype none

package ptg_pkg;

  localparam int unsigned SAMPLE_RATE = 8000;
  localparam int unsigned DAC_MID     = 2048;
  localparam int unsigned MAX_VOL     = 6;
  localparam int unsigned DUTY_PCT    = 10;
  localparam int unsigned AMP_MAX     = 127;

  localparam logic [63:0] PHASE_ONE = 64'h1_0000_0000;
  localparam logic [63:0] TOP_BIT   = 64'h8000_0000;

  localparam logic [11:0] DAC_MAX    = 12'hFFF;
  localparam logic [11:0] MID        = 12'(DAC_MID);
  localparam logic [19:0] CNT_MAX    = 20'hF_FFFF;
  localparam logic [2:0]  VOL_CLAMP  = 3'(MAX_VOL);
  localparam logic [30:0] DUTY_LIMIT = 31'((TOP_BIT * DUTY_PCT) / 100);

  // Phase increment: freq * 2^32 / rate = freq * PHASE_Q + freq * PHASE_RM / rate.
  // PHASE_Q also serves as the reciprocal of the rate scaled by 2^32.
  localparam logic [22:0] PHASE_Q  = 23'(PHASE_ONE / SAMPLE_RATE);
  localparam logic [15:0] PHASE_RM = 16'(PHASE_ONE % SAMPLE_RATE);
  localparam logic [15:0] RATE_W   = 16'(SAMPLE_RATE);

  // Sample count: ceil(dur * rate / 1000) = dur * CNT_A + ceil(dur * CNT_B / 1000).
  localparam logic [5:0]  CNT_A    = 6'(SAMPLE_RATE / 1000);
  localparam logic [9:0]  CNT_B    = 10'(SAMPLE_RATE % 1000);
  localparam logic [9:0]  MS_ROUND = 10'd999;
  localparam logic [9:0]  MS_DIV   = 10'd1000;
  localparam logic [22:0] MS_RECIP = 23'(PHASE_ONE / 1000);

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_PLAY = 2'd1,
    OP_STOP = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] freq_hz;
    logic [15:0] tone_ms;
    logic [7:0]  vol_pct;
  } ptg_in_t;

  typedef struct packed {
    logic [11:0] dac_sample;
    logic        playing;
  } ptg_out_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  op;
    logic        start;
    logic [31:0] phase_inc;
    logic [19:0] sample_cnt;
    logic [6:0]  amplitude;
  } ptg_cmd_t;

  function automatic logic [6:0] amp_of(int unsigned vol);
    int unsigned amp;
    amp = ((DAC_MID - 1) * vol) / 100;
    if (amp > AMP_MAX) begin
      amp = AMP_MAX;
    end
    return 7'(amp);
  endfunction

  localparam logic [6:0] AMP_TABLE [7] = '{
    amp_of(0), amp_of(1), amp_of(2), amp_of(3), amp_of(4), amp_of(5), amp_of(6)
  };

endpackage

`default_nettype wire

// ----- design/ptg_prep.sv -----
// ----------------------------------------------------------------------------
// Pulse tone generator request preparation
// Registers each request and works out the phase increment, sample count
// and amplitude of a play request over three pipeline stages.
// ----------------------------------------------------------------------------
`default_nettype none

module ptg_prep (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              in_valid_i,
  input  ptg_pkg::ptg_in_t  in_data_i,
  output ptg_pkg::ptg_cmd_t cmd_o
);
  import ptg_pkg::*;

  // Stage 1: input register.
  logic    s1_valid_q;
  ptg_in_t s1_q;

  logic        s1_start;
  logic [2:0]  s1_vol;
  logic [38:0] s1_base;
  logic [31:0] s1_z;
  logic [21:0] s1_c1;
  logic [26:0] s1_w;

  // Stage 2.
  logic        s2_valid_q;
  logic [1:0]  s2_op_q;
  logic        s2_start_q;
  logic [6:0]  s2_amp_q;
  logic [31:0] s2_base_q;
  logic [31:0] s2_z_q;
  logic [21:0] s2_c1_q;
  logic [26:0] s2_w_q;

  logic [54:0] s2_pz;
  logic [49:0] s2_pw;

  // Stage 3.
  logic        s3_valid_q;
  logic [1:0]  s3_op_q;
  logic        s3_start_q;
  logic [6:0]  s3_amp_q;
  logic [31:0] s3_base_q;
  logic [31:0] s3_z_q;
  logic [21:0] s3_c1_q;
  logic [26:0] s3_w_q;
  logic [15:0] s3_ep_q;
  logic [16:0] s3_ec_q;

  logic [31:0] s3_rp;
  logic [15:0] s3_qp;
  logic [26:0] s3_rc;
  logic [16:0] s3_qc;
  logic [22:0] s3_cnt_full;
  logic [19:0] s3_cnt;

  // Stage 4: prepared command.
  logic        s4_valid_q;
  logic [1:0]  s4_op_q;
  logic        s4_start_q;
  logic [31:0] s4_inc_q;
  logic [19:0] s4_cnt_q;
  logic [6:0]  s4_amp_q;

  always_comb begin
    s1_start = (s1_q.op == OP_PLAY) && (s1_q.freq_hz != 16'd0) &&
               (s1_q.tone_ms != 16'd0);
    s1_vol   = (s1_q.vol_pct > 8'(MAX_VOL)) ? VOL_CLAMP
                                            : s1_q.vol_pct[2:0];
    s1_base  = {23'd0, s1_q.freq_hz} * {16'd0, PHASE_Q};
    s1_z     = {16'd0, s1_q.freq_hz} * {16'd0, PHASE_RM};
    s1_c1    = {6'd0, s1_q.tone_ms} * {16'd0, CNT_A};
    s1_w     = {11'd0, s1_q.tone_ms} * {17'd0, CNT_B} + {17'd0, MS_ROUND};
  end

  always_comb begin
    s2_pz = {23'd0, s2_z_q} * {32'd0, PHASE_Q};
    s2_pw = {23'd0, s2_w_q} * {27'd0, MS_RECIP};
  end

  // The reciprocal estimates are at most one low, so one correction step suffices.
  always_comb begin
    s3_rp       = s3_z_q - ({16'd0, s3_ep_q} * {16'd0, RATE_W});
    s3_qp       = s3_ep_q + 16'(s3_rp >= {16'd0, RATE_W});
    s3_rc       = s3_w_q - ({10'd0, s3_ec_q} * {17'd0, MS_DIV});
    s3_qc       = s3_ec_q + 17'(s3_rc >= {17'd0, MS_DIV});
    s3_cnt_full = {1'b0, s3_c1_q} + {6'd0, s3_qc};
    if (s3_cnt_full > {3'd0, CNT_MAX}) begin
      s3_cnt = CNT_MAX;
    end else if (s3_cnt_full == 23'd0) begin
      s3_cnt = 20'd1;
    end else begin
      s3_cnt = s3_cnt_full[19:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q       <= in_data_i;

      s2_op_q    <= s1_q.op;
      s2_start_q <= s1_start;
      s2_amp_q   <= AMP_TABLE[s1_vol];
      s2_base_q  <= s1_base[31:0];
      s2_z_q     <= s1_z;
      s2_c1_q    <= s1_c1;
      s2_w_q     <= s1_w;

      s3_op_q    <= s2_op_q;
      s3_start_q <= s2_start_q;
      s3_amp_q   <= s2_amp_q;
      s3_base_q  <= s2_base_q;
      s3_z_q     <= s2_z_q;
      s3_c1_q    <= s2_c1_q;
      s3_w_q     <= s2_w_q;
      s3_ep_q    <= s2_pz[47:32];
      s3_ec_q    <= s2_pw[48:32];

      s4_op_q    <= s3_op_q;
      s4_start_q <= s3_start_q;
      s4_inc_q   <= s3_base_q + {16'd0, s3_qp};
      s4_cnt_q   <= s3_cnt;
      s4_amp_q   <= s3_amp_q;
    end
  end

  always_comb begin
    cmd_o.valid      = s4_valid_q;
    cmd_o.op         = s4_op_q;
    cmd_o.start      = s4_start_q;
    cmd_o.phase_inc  = s4_inc_q;
    cmd_o.sample_cnt = s4_cnt_q;
    cmd_o.amplitude  = s4_amp_q;
  end

endmodule

`default_nettype wire

// ----- design/ptg_core.sv -----
// ----------------------------------------------------------------------------
// Pulse tone generator core
// Holds the tone state, executes prepared requests and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module ptg_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  ptg_pkg::ptg_cmd_t cmd_i,
  output logic              out_valid_o,
  output ptg_pkg::ptg_out_t out_data_o
);
  import ptg_pkg::*;

  logic [31:0] acc_q, acc_d;
  logic [31:0] inc_q, inc_d;
  logic [19:0] rem_q, rem_d;
  logic [6:0]  amp_q, amp_d;
  logic        active_q, active_d;

  logic        out_valid_q, out_valid_d;
  ptg_out_t    out_data_q, out_data_d;

  logic [12:0] sum;

  always_comb begin
    acc_d       = acc_q;
    inc_d       = inc_q;
    rem_d       = rem_q;
    amp_d       = amp_q;
    active_d    = active_q;
    out_valid_d = 1'b0;
    out_data_d  = '{dac_sample: MID, playing: 1'b0};
    sum         = {1'b0, MID} + {6'd0, amp_q};

    if (cmd_i.valid) begin
      unique case (cmd_i.op) inside
        OP_PLAY, OP_STOP: begin
          if ((cmd_i.op == OP_PLAY) && cmd_i.start) begin
            acc_d    = 32'd0;
            inc_d    = cmd_i.phase_inc;
            rem_d    = cmd_i.sample_cnt;
            amp_d    = cmd_i.amplitude;
            active_d = 1'b1;
          end else begin
            active_d    = 1'b0;
            rem_d       = 20'd0;
            inc_d       = 32'd0;
            out_valid_d = 1'b1;
          end
        end
        OP_TICK: begin
          if (active_q && (rem_q != 20'd0)) begin
            if (acc_q[30:0] < DUTY_LIMIT) begin
              if (!acc_q[31]) begin
                out_data_d.dac_sample = sum[12] ? DAC_MAX : sum[11:0];
              end else if (MID >= {5'd0, amp_q}) begin
                out_data_d.dac_sample = MID - {5'd0, amp_q};
              end else begin
                out_data_d.dac_sample = 12'd0;
              end
            end
            acc_d = acc_q + inc_q;
            rem_d = rem_q - 20'd1;
          end else begin
            active_d = 1'b0;
          end
          if (rem_d == 20'd0) begin
            active_d = 1'b0;
          end
          out_data_d.playing = active_d;
          out_valid_d        = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= 32'd0;
      inc_q       <= 32'd0;
      rem_q       <= 20'd0;
      amp_q       <= 7'd0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      acc_q       <= acc_d;
      inc_q       <= inc_d;
      rem_q       <= rem_d;
      amp_q       <= amp_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ----- design/pulse_tone_generator.sv -----
// ----------------------------------------------------------------------------
// Pulse tone generator
// Timed pulse tone source for a 12-bit DAC, driven by tick, play and stop
// requests.
// ----------------------------------------------------------------------------
// Usage:
// The input channel takes one request per accepted valid/ready handshake.
// A tick request returns one DAC sample and the playing flag. A play request
// arms a tone and returns nothing, unless its frequency or duration is zero,
// in which case it behaves as a stop. A stop request silences the tone and
// returns the midscale sample. The unused opcode is dropped without a result.
// A result reaches the output channel through prep stages 1 to 4 and the
// core's result register. Unless the receiver stalls, the pipeline takes one
// request per cycle: the phase increment and sample count divisions by
// constants are split over three stages, and all tone state is updated in the
// final stage, so back-to-back requests see each other's effects in order.
// Reset clears the tone state and empties the pipeline; the first tick after
// reset returns midscale with playing low.
// When the receiver stalls with a result pending, the whole pipeline holds
// and in_ready_o falls until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module pulse_tone_generator (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ptg_pkg::ptg_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ptg_pkg::ptg_out_t out_data_o
);
  import ptg_pkg::*;

  logic     en;
  logic     res_valid;
  ptg_cmd_t cmd;

  assign en          = !res_valid || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = res_valid;

  ptg_prep u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .cmd_o      (cmd)
  );

  ptg_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .cmd_i       (cmd),
    .out_valid_o (res_valid),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ----- design/ptg_checker.sv -----
// ----------------------------------------------------------------------------
// Pulse tone generator checker
// Port-level assertions for the pulse tone generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "pulse_tone_generator_defines.svh"

module ptg_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input ptg_pkg::ptg_out_t out_data_o
);
  import ptg_pkg::*;

  localparam logic [11:0] SAMPLE_HI =
    12'(((DAC_MID + AMP_MAX) > 4095) ? 4095 : (DAC_MID + AMP_MAX));
  localparam logic [11:0] SAMPLE_LO =
    12'((DAC_MID > AMP_MAX) ? (DAC_MID - AMP_MAX) : 0);

  `PTG_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !out_valid_o, "result valid during reset")

  `PTG_ASSERT(a_ready_follows_out, in_ready_o == (!out_valid_o || out_ready_i), "ready mismatch")

  `PTG_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o), "result changed while stalled")

  `PTG_ASSERT(a_sample_range, out_valid_o |-> (out_data_o.dac_sample >= SAMPLE_LO) && (out_data_o.dac_sample <= SAMPLE_HI), "sample outside tone range")

endmodule

bind pulse_tone_generator ptg_checker u_ptg_checker (.*);

`default_nettype wire
